// File: rtl/core/mcfs_pkg.sv
// ----------------------------------------------------------------------------
// mcfs_pkg
// Shared types and codes for the multi-channel FIFO with select.
// ----------------------------------------------------------------------------
package mcfs_pkg;

	localparam logic [2:0] CMD_OPEN    = 3'd0;
	localparam logic [2:0] CMD_SEND    = 3'd1;
	localparam logic [2:0] CMD_RECEIVE = 3'd2;
	localparam logic [2:0] CMD_CLOSE   = 3'd3;
	localparam logic [2:0] CMD_SELECT  = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_CLOSED = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam int FIELD_CHANNELS = 8;

	typedef struct packed {
		logic [2:0]         command;
		logic [2:0]         channel;
		logic signed [63:0] data_value;
		logic [7:0]         select_mask;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] result_value;
		logic [2:0]         chosen_channel;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]         op;
		logic               channel_ok;
		logic [2:0]         channel;
		logic signed [63:0] data_value;
		logic [7:0]         select_mask;
	} cmd_t;

endpackage

// File: rtl/core/multi_channel_fifo_select.sv
// ----------------------------------------------------------------------------
// multi_channel_fifo_select
// Set of ring-buffer channels with close flags and a masked select.
// ----------------------------------------------------------------------------
// A request that moves no data (open, close, send, and receive or select
// that finds nothing to pop) loads the response register directly; a receive
// or select that pops goes through the read data register first, since the
// slot memory has a registered read port, and it holds off the next command.
// A two-entry command queue sits between the request port and the back end,
// and the response register frees the back end as soon as the response is
// taken, so responses can leave every cycle when no pop or stall intervenes.
module multi_channel_fifo_select #(
	parameter int NUM_CHANNELS = 8,
	parameter int SLOT_DEPTH   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mcfs_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mcfs_pkg::rsp_item_t rsp
);

	mcfs_pkg::cmd_t     cmd;
	logic               cmd_valid;
	logic               cmd_pop;

	mcfs_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cmd_pop  (cmd_pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	mcfs_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SLOT_DEPTH  (SLOT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// File: rtl/core/mcfs_front.sv
// ----------------------------------------------------------------------------
// mcfs_front
// Accepts requests, checks the channel and mask against the channel count,
// and holds decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module mcfs_front #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  mcfs_pkg::req_item_t req,
	input  logic               cmd_pop,
	output logic               cmd_valid,
	output mcfs_pkg::cmd_t     cmd
);

	mcfs_pkg::cmd_t cls;
	mcfs_pkg::cmd_t buf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;

	always_comb begin
		cls.op         = req.command;
		cls.channel    = req.channel;
		cls.channel_ok = (32'(req.channel) < NUM_CHANNELS);
		cls.data_value = req.data_value;
		for (int i = 0; i < mcfs_pkg::FIELD_CHANNELS; i++) begin
			cls.select_mask[i] = req.select_mask[i] && (i < NUM_CHANNELS);
		end
	end

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("command queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != 2'd0)
		else $error("pop from empty command queue");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) && !cmd_pop |=> count_q == 2'd2)
		else $error("queue count dropped without a pop");

endmodule

// File: rtl/core/mcfs_back.sv
// ----------------------------------------------------------------------------
// mcfs_back
// Executes one command at a time against the channel state and the slot
// memory, and holds the response in an output register.
// ----------------------------------------------------------------------------
module mcfs_back #(
	parameter int NUM_CHANNELS = 8,
	parameter int SLOT_DEPTH   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  mcfs_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mcfs_pkg::rsp_item_t rsp
);

	localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PW    = $clog2(SLOT_DEPTH);
	localparam int FW    = $clog2(SLOT_DEPTH + 1);
	localparam int AW    = $clog2(NUM_CHANNELS * SLOT_DEPTH);
	localparam int SELW  = (NUM_CHANNELS < mcfs_pkg::FIELD_CHANNELS) ?
		NUM_CHANNELS : mcfs_pkg::FIELD_CHANNELS;
	localparam int DEPTH = NUM_CHANNELS * SLOT_DEPTH;

	logic [PW-1:0]     rp_q     [NUM_CHANNELS];
	logic [FW-1:0]     fill_q   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] closed_q;
	logic [63:0]       mem      [DEPTH];
	logic [63:0]       rd_data_q;

	logic              rsp_valid_q;
	mcfs_pkg::rsp_item_t rsp_q;
	logic              pend_q;
	logic [1:0]        pend_status_q;
	logic [2:0]        pend_chan_q;

	logic              go;
	logic [CW-1:0]     tgt;
	logic [SELW-1:0]   cand;
	logic              found;
	logic [CW-1:0]     sel;
	logic [FW-1:0]     fill_t;
	logic [PW-1:0]     rp_t;
	logic [FW:0]       tail_sum;
	logic [PW-1:0]     tail;
	logic [PW-1:0]     rp_nxt;
	logic [PW-1:0]     slot_idx;
	logic [AW-1:0]     addr;
	logic              do_clear;
	logic              do_close;
	logic              do_write;
	logic              do_pop;
	logic [1:0]        status;
	logic [2:0]        chosen;

	assign go      = cmd_valid && !pend_q && (!rsp_valid_q || !rsp_stall);
	assign cmd_pop = go;

	always_comb begin
		for (int i = 0; i < SELW; i++) begin
			cand[i] = cmd.select_mask[i] && ((fill_q[i] != '0) || closed_q[i]);
		end
		found = 1'b0;
		sel   = '0;
		for (int i = SELW - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found = 1'b1;
				sel   = CW'(i);
			end
		end
	end

	always_comb begin
		tgt = (cmd.op == mcfs_pkg::CMD_SELECT) ? sel : CW'(cmd.channel);
		fill_t   = fill_q[tgt];
		rp_t     = rp_q[tgt];
		tail_sum = (FW+1)'(rp_t) + (FW+1)'(fill_t);
		tail     = (tail_sum >= (FW+1)'(SLOT_DEPTH)) ?
			PW'(tail_sum - (FW+1)'(SLOT_DEPTH)) : PW'(tail_sum);
		rp_nxt   = (rp_t == PW'(SLOT_DEPTH - 1)) ? '0 : rp_t + PW'(1);

		do_clear = 1'b0;
		do_close = 1'b0;
		do_write = 1'b0;
		do_pop   = 1'b0;
		status   = mcfs_pkg::ST_OK;
		chosen   = cmd.channel;

		case (cmd.op)
			mcfs_pkg::CMD_OPEN: begin
				do_clear = cmd.channel_ok;
			end
			mcfs_pkg::CMD_SEND: begin
				if (!cmd.channel_ok || fill_t == FW'(SLOT_DEPTH)) begin
					status = mcfs_pkg::ST_FULL;
				end else begin
					do_write = 1'b1;
				end
			end
			mcfs_pkg::CMD_RECEIVE: begin
				if (!cmd.channel_ok) begin
					status = mcfs_pkg::ST_EMPTY;
				end else if (fill_t != '0) begin
					do_pop = 1'b1;
				end else if (closed_q[tgt]) begin
					status = mcfs_pkg::ST_CLOSED;
				end else begin
					status = mcfs_pkg::ST_EMPTY;
				end
			end
			mcfs_pkg::CMD_CLOSE: begin
				do_close = cmd.channel_ok;
			end
			mcfs_pkg::CMD_SELECT: begin
				if (!found) begin
					status = mcfs_pkg::ST_EMPTY;
				end else begin
					chosen = 3'(sel);
					if (fill_t != '0) begin
						do_pop = 1'b1;
					end else begin
						status = mcfs_pkg::ST_CLOSED;
					end
				end
			end
			default: begin
				status = mcfs_pkg::ST_OK;
			end
		endcase

		slot_idx = do_pop ? rp_t : tail;
		addr     = AW'(tgt) * AW'(SLOT_DEPTH) + AW'(slot_idx);
	end

	always_ff @(posedge clk) begin
		if (go && do_write) begin
			mem[addr] <= cmd.data_value;
		end
		if (go && do_pop) begin
			rd_data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				rp_q[c]   <= '0;
				fill_q[c] <= '0;
			end
			closed_q <= '0;
		end else if (go) begin
			if (do_clear) begin
				rp_q[tgt]     <= '0;
				fill_q[tgt]   <= '0;
				closed_q[tgt] <= 1'b0;
			end
			if (do_close) begin
				closed_q[tgt] <= 1'b1;
			end
			if (do_write) begin
				fill_q[tgt] <= fill_t + FW'(1);
			end
			if (do_pop) begin
				rp_q[tgt]   <= rp_nxt;
				fill_q[tgt] <= fill_t - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			rsp_q.status         <= pend_status_q;
			rsp_q.result_value   <= rd_data_q;
			rsp_q.chosen_channel <= pend_chan_q;
		end else if (go) begin
			pend_status_q <= status;
			pend_chan_q   <= chosen;
			if (!do_pop) begin
				rsp_q.status         <= status;
				rsp_q.result_value   <= '0;
				rsp_q.chosen_channel <= chosen;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (pend_q) begin
			rsp_valid_q <= 1'b1;
			pend_q      <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= !do_pop;
			pend_q      <= do_pop;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_pend_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !rsp_valid_q)
		else $error("read pending while response register busy");

	a_pend_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> rsp_valid_q && !pend_q)
		else $error("pending read did not reach the response register");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= FW'(SLOT_DEPTH))
		else $error("channel fill count above depth");

	a_no_exec_while_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !cmd_pop)
		else $error("command taken during a pending read");

endmodule

// File: test/tb_multi_channel_fifo_select.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_fifo_select
// Self-checking bench for the multi-channel FIFO with masked select. A
// scoreboard object keeps its own copy of every channel's ring, fill level
// and close flag. It predicts the response to each accepted request and
// compares responses in order. Directed requests come first, then random
// traffic in bursts under several idle and stall mixes, then one long
// response hold-off that backs up the request port.
// ----------------------------------------------------------------------------
module tb_multi_channel_fifo_select;
	timeunit 1ns;
	timeprecision 1ps;

	import mcfs_pkg::*;

	localparam int NUM_CH     = FIELD_CHANNELS;
	localparam int SLOT_DEPTH = 16;
	localparam int LIMIT      = 200000;

	class fifo_select_scoreboard;
		logic [63:0] slots [NUM_CH][SLOT_DEPTH];
		int          head [NUM_CH];
		int          fill [NUM_CH];
		bit          closed [NUM_CH];
		rsp_item_t   expected_q [$];
		int          requests;
		int          responses;
		int          errors;
		int          status_seen [4];

		function new();
			for (int c = 0; c < NUM_CH; c++) begin
				head[c] = 0;
				fill[c] = 0;
				closed[c] = 1'b0;
			end
			for (int s = 0; s < 4; s++)
				status_seen[s] = 0;
			requests = 0;
			responses = 0;
			errors = 0;
		endfunction

		function logic [63:0] pop_slot(input int c);
			logic [63:0] v;
			v = slots[c][head[c]];
			head[c] = (head[c] + 1) % SLOT_DEPTH;
			fill[c]--;
			return v;
		endfunction

		function void note_request(input req_item_t r);
			rsp_item_t e;
			int        c;
			c = r.channel;
			e.status = ST_OK;
			e.result_value = '0;
			e.chosen_channel = r.channel;
			case (r.command)
				CMD_OPEN: begin
					head[c] = 0;
					fill[c] = 0;
					closed[c] = 1'b0;
				end
				CMD_SEND: begin
					if (fill[c] >= SLOT_DEPTH) begin
						e.status = ST_FULL;
					end else begin
						slots[c][(head[c] + fill[c]) % SLOT_DEPTH] = r.data_value;
						fill[c]++;
					end
				end
				CMD_RECEIVE: begin
					if (fill[c] > 0)
						e.result_value = pop_slot(c);
					else
						e.status = closed[c] ? ST_CLOSED : ST_EMPTY;
				end
				CMD_CLOSE: closed[c] = 1'b1;
				CMD_SELECT: begin
					e.status = ST_EMPTY;
					for (int i = 0; i < NUM_CH; i++) begin
						if (r.select_mask[i]) begin
							if (fill[i] > 0) begin
								e.result_value = pop_slot(i);
								e.status = ST_OK;
								e.chosen_channel = 3'(i);
								break;
							end
							if (closed[i]) begin
								e.status = ST_CLOSED;
								e.chosen_channel = 3'(i);
								break;
							end
						end
					end
				end
				default: ;
			endcase
			status_seen[e.status]++;
			requests++;
			expected_q.push_back(e);
		endfunction

		function void check_response(input rsp_item_t got);
			rsp_item_t e;
			responses++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("response %0d arrived with nothing expected", responses);
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status || got.result_value !== e.result_value ||
				got.chosen_channel !== e.chosen_channel) begin
				errors++;
				if (errors <= 10)
					$display("response %0d: expected status %0d value %h channel %0d, %s %0d %h %0d",
						responses, e.status, e.result_value, e.chosen_channel,
						"got", got.status, got.result_value, got.chosen_channel);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_item_t   req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp;

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_len = 0;
	int          hold_count = 0;
	int unsigned cycle_count = 0;

	fifo_select_scoreboard sb = new();

	multi_channel_fifo_select #(
		.NUM_CHANNELS(NUM_CH),
		.SLOT_DEPTH  (SLOT_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("multi_channel_fifo_select: mismatch");
			$finish;
		end
	end

	// hold off responses once for a run set by hold_len, then stall at random
	always @(posedge clk) begin
		if (hold_count < hold_len) begin
			rsp_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	function automatic req_item_t make_req(input logic [2:0] cmd, input logic [2:0] ch,
		input logic [63:0] data, input logic [7:0] mask);
		req_item_t r;
		r.command = cmd;
		r.channel = ch;
		r.data_value = data;
		r.select_mask = mask;
		return r;
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] rand_mask();
		case ($urandom_range(3))
			0: return 8'h01 << $urandom_range(7);
			1: return 8'($urandom);
			2: return 8'hFF;
			default: return 8'($urandom & $urandom);
		endcase
	endfunction

	task automatic push_request(input req_item_t item);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic random_traffic(input int total);
		int         n;
		int         pick;
		int         k;
		logic [2:0] ch;
		n = 0;
		while (n < total) begin
			pick = $urandom_range(99);
			ch = 3'($urandom_range(7));
			k = $urandom_range(1, 20);
			if (pick < 30) begin
				repeat (k) push_request(make_req(CMD_SEND, ch, rand_word(), 8'($urandom)));
			end else if (pick < 55) begin
				repeat (k) push_request(make_req(CMD_RECEIVE, ch, rand_word(), 8'($urandom)));
			end else if (pick < 72) begin
				k = $urandom_range(1, 6);
				repeat (k) push_request(make_req(CMD_SELECT, ch, rand_word(), rand_mask()));
			end else if (pick < 82) begin
				k = 1;
				push_request(make_req(CMD_CLOSE, ch, rand_word(), 8'($urandom)));
			end else if (pick < 90) begin
				k = 1;
				push_request(make_req(CMD_OPEN, ch, rand_word(), 8'($urandom)));
			end else begin
				k = 1;
				push_request(make_req(3'($urandom_range(7)), ch, rand_word(), 8'($urandom)));
			end
			n += k;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_request(make_req(CMD_OPEN, 3'd0, '0, '0));
		push_request(make_req(CMD_SEND, 3'd0, 64'h8000_0000_0000_0000, '0));
		push_request(make_req(CMD_SEND, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF, '0));
		push_request(make_req(CMD_SEND, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0));
		push_request(make_req(CMD_RECEIVE, 3'd0, '0, '0));
		push_request(make_req(CMD_SELECT, 3'd6, '0, 8'h01));
		push_request(make_req(CMD_RECEIVE, 3'd0, '0, 8'hFF));
		push_request(make_req(CMD_RECEIVE, 3'd0, '1, '0));
		push_request(make_req(CMD_SELECT, 3'd5, '1, 8'h00));
		push_request(make_req(CMD_CLOSE, 3'd7, '0, '0));
		push_request(make_req(CMD_SEND, 3'd7, 64'h0123_4567_89AB_CDEF, '0));
		push_request(make_req(CMD_SELECT, 3'd2, '0, 8'hFF));
		push_request(make_req(CMD_SELECT, 3'd2, '0, 8'hFF));
		push_request(make_req(CMD_RECEIVE, 3'd7, '0, '0));
		push_request(make_req(CMD_CLOSE, 3'd7, '0, '0));
		push_request(make_req(CMD_OPEN, 3'd7, '0, '0));
		push_request(make_req(CMD_RECEIVE, 3'd7, '0, '0));
		push_request(make_req(CMD_CLOSE, 3'd3, '0, '0));
		push_request(make_req(CMD_SEND, 3'd5, 64'hFEDC_BA98_7654_3210, '0));
		push_request(make_req(CMD_SELECT, 3'd1, '0, 8'h28));
		push_request(make_req(CMD_SELECT, 3'd1, '0, 8'h20));
		push_request(make_req(3'd5, 3'd4, rand_word(), 8'($urandom)));
		push_request(make_req(3'd6, 3'd2, rand_word(), 8'($urandom)));
		push_request(make_req(3'd7, 3'd1, rand_word(), 8'($urandom)));
		push_request(make_req(CMD_OPEN, 3'd3, '0, '0));

		random_traffic(420);
		idle_pct = 72;
		random_traffic(420);
		idle_pct = 0;
		stall_pct <= 72;
		random_traffic(420);
		idle_pct = 16;
		stall_pct <= 16;
		random_traffic(420);

		// back up the request port behind a long response hold-off
		idle_pct = 0;
		stall_pct <= 0;
		hold_len <= 400;
		random_traffic(120);

		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d requests and %0d responses over four idle/stall mixes and a hold-off",
			sb.requests, sb.responses);
		$display("statuses seen: %0d ok, %0d empty, %0d closed, %0d full",
			sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
			sb.status_seen[ST_CLOSED], sb.status_seen[ST_FULL]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("multi_channel_fifo_select: match");
		end else begin
			$display("multi_channel_fifo_select: mismatch");
		end
		$finish;
	end

endmodule
